>>> hdl/ins_sort_pkg.sv
// ins_sort_pkg: beat types and controller/datapath interface for insertion_sorter
// no dependencies; used by ins_sort_ctrl, ins_sort_dp and insertion_sorter
package ins_sort_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_result;
        logic                      overflow;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic drop;
        logic shift_step;
        logic place;
        logic emit_rd;
        logic emit_end;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic in_last;
        logic held_last;
        logic pos_zero;
        logic greater;
        logic emit_done;
    } t_dp_sts;

endpackage

>>> hdl/ins_sort_ctrl.sv
// ins_sort_ctrl: sequencer for insertion and emission
// depends on ins_sort_pkg
module ins_sort_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ins_sort_pkg::t_dp_sts i_sts,
    output ins_sort_pkg::t_dp_cmd o_cmd
);

    ins_sort_pkg::t_state r_state;
    ins_sort_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ins_sort_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            ins_sort_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.drop = 1'b1;
                        n_state = i_sts.in_last ? ins_sort_pkg::ST_EMIT
                                                : ins_sort_pkg::ST_IDLE;
                    end else begin
                        n_state = ins_sort_pkg::ST_SHIFT;
                    end
                end
            end
            ins_sort_pkg::ST_SHIFT: begin
                if (!i_sts.pos_zero && i_sts.greater) begin
                    o_cmd.shift_step = 1'b1;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state = i_sts.held_last ? ins_sort_pkg::ST_EMIT
                                              : ins_sort_pkg::ST_IDLE;
                end
            end
            ins_sort_pkg::ST_EMIT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_sts.emit_done) begin
                    o_cmd.emit_end = 1'b1;
                    n_state = ins_sort_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ins_sort_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ins_sort_dp.sv
// ins_sort_dp: element store, count, insertion pointer and result register
// depends on ins_sort_pkg
module ins_sort_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ins_sort_pkg::t_in_beat  i_item,
    input  ins_sort_pkg::t_dp_cmd   i_cmd,
    output ins_sort_pkg::t_dp_sts   o_sts,
    output ins_sort_pkg::t_out_beat o_result,
    output logic                    o_result_valid
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [ins_sort_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [ins_sort_pkg::VALUE_W-1:0] r_rd_data;
    logic signed [ins_sort_pkg::VALUE_W-1:0] r_val;
    logic                                    r_last;
    logic [CW-1:0]                           r_count;
    logic                                    r_dropped;
    logic [CW-1:0]                           r_pos;
    logic [AW-1:0]                           r_idx;
    logic                                    r_strobe;
    logic                                    r_out_last;
    logic                                    r_out_ovf;

    logic [CW-1:0]                           w_cnt_m1;
    logic [CW-1:0]                           w_pos_m2;
    logic [AW-1:0]                           w_rd_addr;
    logic                                    w_wr_en;
    logic signed [ins_sort_pkg::VALUE_W-1:0] w_wr_data;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_pos_m2 = r_pos - CW'(2);

    always_comb begin
        if (i_cmd.accept) begin
            w_rd_addr = w_cnt_m1[AW-1:0];
        end else if (i_cmd.shift_step) begin
            w_rd_addr = w_pos_m2[AW-1:0];
        end else begin
            w_rd_addr = r_idx;
        end
    end

    assign w_wr_en   = i_cmd.shift_step | i_cmd.place;
    assign w_wr_data = i_cmd.shift_step ? r_rd_data : r_val;

    // store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos[AW-1:0]] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val  <= i_item.value;
            r_last <= i_item.last_item;
        end
        r_out_last <= i_cmd.emit_end;
        r_out_ovf  <= r_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_pos     <= '0;
            r_idx     <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_rd;
            if (i_cmd.accept) begin
                r_pos <= r_count;
            end else if (i_cmd.shift_step) begin
                r_pos <= r_pos - CW'(1);
            end
            if (i_cmd.drop) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit_end) begin
                r_idx     <= '0;
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else if (i_cmd.emit_rd) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.full      = (r_count == CW'(DEPTH));
        o_sts.in_last   = i_item.last_item;
        o_sts.held_last = r_last;
        o_sts.pos_zero  = (r_pos == '0);
        o_sts.greater   = (r_rd_data > r_val);
        o_sts.emit_done = (r_idx == w_cnt_m1[AW-1:0]);
    end

    assign o_result.sorted_value = r_rd_data;
    assign o_result.last_result  = r_out_last;
    assign o_result.overflow     = r_out_ovf;
    assign o_result_valid        = r_strobe;

endmodule

>>> hdl/insertion_sorter.sv
// insertion_sorter: top level, stable ascending sort of signed 32-bit sets
// depends on ins_sort_pkg, ins_sort_ctrl, ins_sort_dp
//
// usage: drive i_item and raise start; a beat is taken on an edge with start
// high and busy low. last_item closes a set. values beyond DEPTH are dropped
// and every result of that set then carries overflow.
// inserting a value keeps busy high while each stored value larger than it
// is shifted up and then while it is placed: the store has one read and one
// write port, so each cycle moves one element up by one slot. a value dropped
// on a full store is not inserted and raises no busy for an insertion.
// emission follows the last beat: one result per cycle, n results in all, n
// the stored count, each on o_result for one cycle with o_result_valid high,
// the first in the cycle after the emission sweep starts. last_result marks
// the final one. the receiver cannot stall; results are never held.
// reset clears count, overflow and the sequencer; store contents are
// left as they are and only written entries are used.
module insertion_sorter #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  ins_sort_pkg::t_in_beat  i_item,
    output ins_sort_pkg::t_out_beat o_result,
    output logic                    o_result_valid
);

    ins_sort_pkg::t_dp_cmd w_cmd;
    ins_sort_pkg::t_dp_sts w_sts;

    ins_sort_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ins_sort_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    a_strobe_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_cmd.emit_rd))
        else $error("result strobe without a store read");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.last_result |=> !o_result_valid)
        else $error("result after the final beat of a set");

    a_place_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.place |-> !w_sts.full)
        else $error("insertion into a full store");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.shift_step, w_cmd.place, w_cmd.emit_rd}))
        else $error("conflicting datapath commands");

endmodule
